// ===== design/ipl_pkg.sv =====
// Shared types, constants and the control program for the PI loop unit.
// Used by incremental_pi_loop_with_plant_model_unit; depends on nothing else.
package ipl_pkg;

  // Default depth bound of the control-value history.
  localparam int MAX_DELAY_DEF = 16;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_PLANT_COEF_A1 = 3'd0,
    REG_PLANT_COEF_A2 = 3'd1,
    REG_PLANT_GAIN_B  = 3'd2,
    REG_GAIN_NOW      = 3'd3,
    REG_GAIN_LAST     = 3'd4,
    REG_DEAD_TIME     = 3'd5
  } reg_idx_t;

  // Register values after reset.
  localparam logic signed [31:0] A1_RST   = 32'sd519884048;
  localparam logic signed [31:0] A2_RST   = -32'sd251658240;
  localparam logic signed [31:0] B_RST    = 32'sd838861;
  localparam logic signed [31:0] Q0_RST   = 32'sd26843546;
  localparam logic signed [31:0] Q1_RST   = -32'sd26843546;
  localparam logic [4:0]         DEAD_RST = 5'd5;

  // Sequencer top-level state.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_Q0E,
    MUL_Q1EP,
    MUL_A1Y,
    MUL_A2YP,
    MUL_BUD,
    MUL_EE,
    MUL_IDLE
  } mul_sel_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_U0,
    ACC_ADD,
    ACC_LOAD
  } acc_op_t;

  // Step sequencing: go to the next step, or end the program once the
  // output register can take the result (hold here otherwise).
  typedef enum logic {
    SEQ_NEXT,
    SEQ_END
  } seq_op_t;

  typedef struct packed {
    mul_sel_t mul;
    acc_op_t  acc;
    logic     wr_u;
    logic     wr_hist;
    seq_op_t  seq;
  } ucode_t;

  localparam int NSTEPS = 7;
  localparam int STEP_W = $clog2(NSTEPS);

  // Control program, one word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul: MUL_IDLE, acc: ACC_HOLD, wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_END};
    unique case (step)
      3'd0: w = '{mul: MUL_Q0E,  acc: ACC_LOAD_U0, wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_NEXT};
      3'd1: w = '{mul: MUL_Q1EP, acc: ACC_ADD,     wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_NEXT};
      3'd2: w = '{mul: MUL_A1Y,  acc: ACC_ADD,     wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_NEXT};
      3'd3: w = '{mul: MUL_A2YP, acc: ACC_LOAD,    wr_u: 1'b1, wr_hist: 1'b0, seq: SEQ_NEXT};
      3'd4: w = '{mul: MUL_BUD,  acc: ACC_ADD,     wr_u: 1'b0, wr_hist: 1'b1, seq: SEQ_NEXT};
      3'd5: w = '{mul: MUL_EE,   acc: ACC_ADD,     wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_NEXT};
      3'd6: w = '{mul: MUL_IDLE, acc: ACC_HOLD,    wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_END};
      default: w = '{mul: MUL_IDLE, acc: ACC_HOLD, wr_u: 1'b0, wr_hist: 1'b0, seq: SEQ_END};
    endcase
    return w;
  endfunction

  // Saturate a 40-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if ((&x[39:31]) || !(|x[39:31])) begin
      r = x[31:0];
    end else if (x[39]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== design/incremental_pi_loop_with_plant_model_unit.sv =====
// Incremental PI controller closed around a second-order plant with dead time.
// Top level of the block; depends on ipl_pkg.
//
// Usage:
// - Input channel (in_valid / in_stall): one transfer is one sample tick,
//   carrying the setpoint and a restart flag. Restart clears the loop state,
//   the control history and the cost before the tick is worked.
// - Output channel (out_valid / out_stall): one transfer per tick with the
//   plant output used, the new control value and the running cost.
// - Configuration (cfg_we / cfg_index / cfg_wdata): register writes take
//   effect at the clock edge; write only while no tick is in flight.
// The block takes no new tick until the last step of the current one is
// done: six products run one after another through the single 32x32
// multiplier, and one more step saturates the plant sum and updates the cost.
// A waiting result does not block the next tick; if it is still stalled when
// the following result is ready, the sequencer holds in its last step.
// Reset: registers return to their defaults, the loop state and cost clear,
// and the history fill count clears so no old history entry is ever used.
module incremental_pi_loop_with_plant_model_unit
  import ipl_pkg::*;
#(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_setpoint,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_plant_output,
  output logic signed [31:0] out_control_value,
  output logic        [47:0] out_cost_sum,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_wdata
);

  localparam int HIST_LEN = MAX_DELAY + 1;
  localparam int AW       = $clog2(HIST_LEN);
  localparam int CW       = $clog2(HIST_LEN + 1);

  // Configuration registers.
  logic signed [31:0] a1_r, a2_r, b_r, q0_r, q1_r;
  logic        [4:0]  dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r   <= A1_RST;
      a2_r   <= A2_RST;
      b_r    <= B_RST;
      q0_r   <= Q0_RST;
      q1_r   <= Q1_RST;
      dead_r <= DEAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANT_COEF_A1: a1_r   <= cfg_wdata;
        REG_PLANT_COEF_A2: a2_r   <= cfg_wdata;
        REG_PLANT_GAIN_B:  b_r    <= cfg_wdata;
        REG_GAIN_NOW:      q0_r   <= cfg_wdata;
        REG_GAIN_LAST:     q1_r   <= cfg_wdata;
        REG_DEAD_TIME:     dead_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  ucode_t            uc;
  logic              in_xfer, out_busy, step_go, fin;

  // Loop state and datapath registers.
  logic signed [31:0] y_r, yprev_r, eprev_r, u0_r, e_r, u_r;
  logic        [47:0] cost_r;
  logic signed [63:0] prod_r;
  logic signed [39:0] acc_r;
  logic        [AW-1:0] wptr_r;
  logic        [CW-1:0] cnt_r;
  logic signed [31:0] rd_r;
  logic               hist_ok_r;
  logic               out_valid_r;
  logic signed [31:0] out_y_r, out_u_r;
  logic        [47:0] out_cost_r;

  logic signed [31:0] hist_mem [HIST_LEN];

  assign uc       = ucode_rom(step_r);
  assign in_xfer  = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_RUN;
      ST_RUN:  if (uc.seq == SEQ_END && !out_busy) state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    step_go  = 1'b0;
    fin      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN: begin
        step_go = (uc.seq == SEQ_NEXT) || !out_busy;
        fin     = (uc.seq == SEQ_END) && !out_busy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer || fin) begin
        step_r <= '0;
      end else if (step_go) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // Effective delay: values above the history bound act as the bound.
  logic [AW-1:0] d_cur;
  logic [AW:0]   rd_diff;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] y_eff;
  logic signed [32:0] err_diff;

  always_comb begin
    if ({27'b0, dead_r} > 32'(MAX_DELAY)) begin
      d_cur = AW'(MAX_DELAY);
    end else begin
      d_cur = AW'(dead_r);
    end
    rd_diff = {1'b0, wptr_r} - {1'b0, d_cur};
    if (rd_diff[AW]) begin
      rd_addr = AW'(rd_diff + (AW+1)'(HIST_LEN));
    end else begin
      rd_addr = rd_diff[AW-1:0];
    end
    y_eff    = in_restart ? 32'sd0 : y_r;
    err_diff = {in_setpoint[31], in_setpoint} - {y_eff[31], y_eff};
  end

  // History memory: written with the new control value, read at tick start.
  always_ff @(posedge clk) begin
    if (step_go && uc.wr_hist) begin
      hist_mem[wptr_r] <= u_r;
    end
    if (in_xfer) begin
      rd_r <= hist_mem[rd_addr];
    end
  end

  // Shared multiplier operands.
  logic signed [31:0] mul_a, mul_b, ud;
  logic signed [35:0] pq;

  assign ud = (d_cur == '0) ? u_r : (hist_ok_r ? rd_r : 32'sd0);
  assign pq = prod_r[63:28];

  always_comb begin
    mul_a = q0_r;
    mul_b = e_r;
    unique case (uc.mul)
      MUL_Q0E:  begin mul_a = q0_r; mul_b = e_r;     end
      MUL_Q1EP: begin mul_a = q1_r; mul_b = eprev_r; end
      MUL_A1Y:  begin mul_a = a1_r; mul_b = y_r;     end
      MUL_A2YP: begin mul_a = a2_r; mul_b = yprev_r; end
      MUL_BUD:  begin mul_a = b_r;  mul_b = ud;      end
      MUL_EE:   begin mul_a = e_r;  mul_b = e_r;     end
      default:  begin mul_a = q0_r; mul_b = e_r;     end
    endcase
  end

  // Cost update and plant output from the finished sums.
  logic [48:0] cost_sum;
  logic [47:0] cost_new;
  logic signed [31:0] y_next;

  always_comb begin
    cost_sum = {1'b0, cost_r} + {1'b0, prod_r[63:16]};
    cost_new = cost_sum[48] ? '1 : cost_sum[47:0];
    y_next   = sat32(acc_r);
  end

  // Datapath steps.
  always_ff @(posedge clk) begin
    if (step_go) begin
      if (uc.mul != MUL_IDLE) begin
        prod_r <= mul_a * mul_b;
      end
      unique case (uc.acc)
        ACC_HOLD:    ;
        ACC_LOAD_U0: acc_r <= 40'(u0_r);
        ACC_ADD:     acc_r <= acc_r + 40'(pq);
        ACC_LOAD:    acc_r <= 40'(pq);
      endcase
      if (uc.wr_u) begin
        u_r <= sat32(acc_r);
      end
    end
    if (in_xfer) begin
      e_r       <= sat32({{7{err_diff[32]}}, err_diff});
      hist_ok_r <= !in_restart && (32'(d_cur) <= 32'(cnt_r));
    end
    if (fin) begin
      out_y_r    <= y_r;
      out_u_r    <= u_r;
      out_cost_r <= cost_new;
    end
  end

  // Loop state, restart clearing and history bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r     <= '0;
      yprev_r <= '0;
      eprev_r <= '0;
      u0_r    <= '0;
      cost_r  <= '0;
      wptr_r  <= '0;
      cnt_r   <= '0;
    end else if (in_xfer && in_restart) begin
      y_r     <= '0;
      yprev_r <= '0;
      eprev_r <= '0;
      u0_r    <= '0;
      cost_r  <= '0;
      cnt_r   <= '0;
    end else if (fin) begin
      y_r     <= y_next;
      yprev_r <= y_r;
      eprev_r <= e_r;
      u0_r    <= u_r;
      cost_r  <= cost_new;
      wptr_r  <= (wptr_r == AW'(HIST_LEN - 1)) ? '0 : wptr_r + 1'b1;
      if (cnt_r != CW'(HIST_LEN)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_plant_output  = out_y_r;
  assign out_control_value = out_u_r;
  assign out_cost_sum      = out_cost_r;

`ifndef SYNTH
  // The step counter never leaves the program.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> 32'(step_r) < NSTEPS)
    else $error("step counter outside the control program");

  // A finished program always lands in the output register and frees the input.
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished tick did not produce a result");

  // A restart transfer leaves the cost, plant output and history fill count cleared.
  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_restart |=> cost_r == '0 && y_r == '0 && cnt_r == '0)
    else $error("restart did not clear the loop state");

  // History bookkeeping stays inside the memory.
  a_hist_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= HIST_LEN && 32'(wptr_r) < HIST_LEN)
    else $error("history pointer or fill count out of range");

  // A stalled result is never overwritten by the next tick.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy |-> !fin)
    else $error("result overwritten while stalled");
`endif

endmodule
